// ===== rtl/aprb_pkg.sv =====
// ----------------------------------------------------------------------------
// aprb_pkg: shared types and constants for the aging particle ring buffer
// Field widths, operation and register codes, reset values and the
// command / status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package aprb_pkg;

  // Field widths of one input word and one result word
  localparam int OP_W        = 2;
  localparam int TICKS_W     = 16;
  localparam int FREQ_W      = 16;
  localparam int AMP_W       = 16;
  localparam int PAN_W       = 16;
  localparam int TRACK_W     = 3;
  localparam int OFFSET_W    = 12;
  localparam int LIVE_W      = 13;
  localparam int SLOT_OUT_W  = 12;
  localparam int EXPIRED_W   = 13;
  localparam int DIST_W      = 32;
  localparam int RATE_W      = 16;

  // Stored entry: particle fields in the low bits, birth stamp on top
  localparam int PART_W      = FREQ_W + AMP_W + PAN_W + TRACK_W;
  localparam int ENTRY_W     = PART_W + DIST_W;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 128;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD     = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FADE_DISTANCE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RECEDE_RATE   = 2'd1;

  localparam logic [DIST_W-1:0] FADE_DISTANCE_RST = 32'd327680;
  localparam logic [RATE_W-1:0] RECEDE_RATE_RST   = 16'd655;

  typedef struct packed {
    logic capture;
    logic mul;
    logic dist_add;
    logic expire_pop;
    logic add_write;
    logic read_issue;
    logic finish_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            expire_hit;
    logic            out_free;
  } status_t;

endpackage

// ===== rtl/aging_particle_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// aging_particle_ring_buffer: circular particle store with distance expiry
// Advance words move a wrapping Q16.16 distance and drop entries whose age
// reaches the fade distance; add words store a stamped particle, overwriting
// the oldest when full; read words return an entry by offset from the oldest.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | contents
//   --------+-----------+---------------------+-------------------------------
//   s_      | in        | s_tvalid / s_tready | operation in tuser, fields in tdata
//   m_      | out       | m_tvalid / m_tready | one result word per input word
//   cfg_    | in        | cfg_we              | fade distance, recede rate
//
// Add and read words pass an execute step and a finish step; the next word is taken
// in the cycle the result enters the output register. An advance runs one multiply,
// one distance update, then one store read per entry checked on the single read port,
// and then its finish step.
// rst is synchronous: ring empty, head at slot 0, distance zero, registers at
// their reset values. The store itself is not cleared; only written slots are
// ever read as live entries.
// A stalled output holds the result; the block stalls in its final step until
// the output register frees, and a new word may wait behind it meanwhile.
// ----------------------------------------------------------------------------
module aging_particle_ring_buffer #(
  parameter int CAPACITY = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [aprb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [aprb_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input words
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [15:0] elapsed_ticks, [31:16] band_frequency, [47:32] band_amplitude,
  // [63:48] band_pan, [66:64] band_track, [78:67] read_offset, [79] zero
  input  logic [aprb_pkg::IN_TDATA_W-1:0]  s_tdata,
  // [1:0] operation
  input  logic [aprb_pkg::OP_W-1:0]        s_tuser,
  // result words
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [12:0] live_count, [24:13] oldest_slot, [25] overwrote,
  // [38:26] expired_count, [39] entry_valid, [55:40] entry_frequency,
  // [71:56] entry_amplitude, [87:72] entry_pan, [90:88] entry_track,
  // [122:91] entry_birth, [127:123] zero
  output logic [aprb_pkg::OUT_TDATA_W-1:0] m_tdata
);

  aprb_pkg::cmd_t    cmd;
  aprb_pkg::status_t status;

  // Sequencer: dispatch by operation, walk the expiring entries
  aprb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Ring state, store and output register
  aprb_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== rtl/aprb_ram.sv =====
// ----------------------------------------------------------------------------
// aprb_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data; the read
// data holds while no read is issued.
// ----------------------------------------------------------------------------
module aprb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/aprb_ctrl.sv =====
// ----------------------------------------------------------------------------
// aprb_ctrl: sequencing state machine
// Accept a word, dispatch it by operation, walk expiring entries, and hand
// the result to the output register once it is free.
// ----------------------------------------------------------------------------
module aprb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  aprb_pkg::status_t status,
  output aprb_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_EXEC    = 5'b00010,
    ST_ADV_ADD = 5'b00100,
    ST_EXPIRE  = 5'b01000,
    ST_FINISH  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // Take a new word while idle, or while the finished result is being loaded
  assign s_tready = (state == ST_IDLE) || ((state == ST_FINISH) && status.out_free);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd         = '0;
    cmd.capture = accept;
    state_next  = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (status.op)
          aprb_pkg::OP_ADVANCE: begin
            cmd.mul    = 1'b1;
            state_next = ST_ADV_ADD;
          end
          aprb_pkg::OP_ADD: begin
            cmd.add_write = 1'b1;
            state_next    = ST_FINISH;
          end
          aprb_pkg::OP_READ: begin
            cmd.read_issue = 1'b1;
            state_next     = ST_FINISH;
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_ADV_ADD: begin
        cmd.dist_add = 1'b1;
        state_next   = ST_EXPIRE;
      end
      ST_EXPIRE: begin
        if (status.expire_hit) begin
          cmd.expire_pop = 1'b1;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish_load = 1'b1;
          state_next      = accept ? ST_EXEC : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish_load |-> status.out_free)
    else $error("result loaded while output register still full");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_EXEC)
    else $error("accepted word not dispatched");

  a_pop_only_expire: assert property (@(posedge clk) disable iff (rst)
    cmd.expire_pop |=> state == ST_EXPIRE)
    else $error("expiry walk left early");

endmodule

// ===== rtl/aprb_dp.sv =====
// ----------------------------------------------------------------------------
// aprb_dp: datapath of the aging particle ring buffer
// Holds configuration, head slot, live count, distance accumulator, the
// captured word, the entry store and the output register.
// ----------------------------------------------------------------------------
module aprb_dp #(
  parameter int CAPACITY = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [aprb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [aprb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [aprb_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic [aprb_pkg::OP_W-1:0]           s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [aprb_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  aprb_pkg::cmd_t                      cmd,
  output aprb_pkg::status_t                   status
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > aprb_pkg::OFFSET_W) ? CNT_W : aprb_pkg::OFFSET_W;
  localparam logic [SLOT_W:0]  CAP_EXT  = (SLOT_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
  localparam int OUT_PAD_W = aprb_pkg::OUT_TDATA_W - aprb_pkg::LIVE_W
                             - aprb_pkg::SLOT_OUT_W - 1 - aprb_pkg::EXPIRED_W - 1
                             - aprb_pkg::ENTRY_W;

  function automatic logic [SLOT_W-1:0] wrap_add(input logic [SLOT_W-1:0] a,
                                                 input logic [SLOT_W-1:0] b);
    logic [SLOT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= CAP_EXT) begin
      sum = sum - CAP_EXT;
    end
    return sum[SLOT_W-1:0];
  endfunction

  // Configuration
  logic [aprb_pkg::DIST_W-1:0] fade_distance;
  logic [aprb_pkg::RATE_W-1:0] recede_rate;

  // Ring state
  logic [SLOT_W-1:0]           head;
  logic [CNT_W-1:0]            count;
  logic [aprb_pkg::DIST_W-1:0] distance;
  logic                        full;

  // Captured word
  logic [aprb_pkg::OP_W-1:0]     op_q;
  logic [aprb_pkg::TICKS_W-1:0]  ticks_q;
  logic [aprb_pkg::FREQ_W-1:0]   freq_q;
  logic [aprb_pkg::AMP_W-1:0]    amp_q;
  logic signed [aprb_pkg::PAN_W-1:0] pan_q;
  logic [aprb_pkg::TRACK_W-1:0]  track_q;
  logic [aprb_pkg::OFFSET_W-1:0] offset_q;

  // Per-word working registers
  logic [aprb_pkg::DIST_W-1:0] product;
  logic [CNT_W-1:0]            dropped;
  logic                        overwrote_q;
  logic                        rd_valid_q;

  // Store access
  logic                         ram_we;
  logic [SLOT_W-1:0]            ram_waddr;
  logic [aprb_pkg::ENTRY_W-1:0] ram_wdata;
  logic                         ram_re;
  logic [SLOT_W-1:0]            ram_raddr;
  logic [aprb_pkg::ENTRY_W-1:0] ram_rdata;
  logic [aprb_pkg::DIST_W-1:0]  rd_birth;
  logic [aprb_pkg::DIST_W-1:0]  age;
  logic [aprb_pkg::ENTRY_W-1:0] entry_out;
  logic [SLOT_W-1:0]            head_inc;
  logic [SLOT_W-1:0]            tail_slot;
  logic [SLOT_W-1:0]            read_slot;
  logic                         offset_in_range;
  logic [31:0]                  count32;
  logic [31:0]                  head32;
  logic [31:0]                  dropped32;

  assign full            = (count == CAP_CNT);
  assign head_inc        = wrap_add(head, SLOT_W'(1));
  assign tail_slot       = wrap_add(head, SLOT_W'(count));
  assign read_slot       = wrap_add(head, SLOT_W'(offset_q));
  assign offset_in_range = CMP_W'(offset_q) < CMP_W'(count);

  assign rd_birth = ram_rdata[aprb_pkg::ENTRY_W-1:aprb_pkg::PART_W];
  assign age      = distance - rd_birth;

  assign ram_we    = cmd.add_write;
  assign ram_waddr = full ? head : tail_slot;
  assign ram_wdata = {distance, track_q, pan_q, amp_q, freq_q};

  // Pick the read address: head after the distance update, the next slot
  // while popping, or the offset slot for a read
  always_comb begin
    ram_re    = 1'b1;
    ram_raddr = head;
    priority if (cmd.dist_add) begin
      ram_raddr = head;
    end else if (cmd.expire_pop) begin
      ram_raddr = head_inc;
    end else if (cmd.read_issue) begin
      ram_raddr = read_slot;
    end else begin
      ram_re = 1'b0;
    end
  end

  aprb_ram #(
    .WIDTH (aprb_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_distance <= aprb_pkg::FADE_DISTANCE_RST;
      recede_rate   <= aprb_pkg::RECEDE_RATE_RST;
    end else if (cfg_we) begin
      if (cfg_index == aprb_pkg::REG_FADE_DISTANCE) begin
        fade_distance <= cfg_data;
      end else if (cfg_index == aprb_pkg::REG_RECEDE_RATE) begin
        recede_rate <= cfg_data[aprb_pkg::RATE_W-1:0];
      end
    end
  end

  // Ring pointers and distance
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      distance <= '0;
    end else begin
      if (cmd.dist_add) begin
        distance <= distance + product;
      end
      if (cmd.expire_pop) begin
        head  <= head_inc;
        count <= count - CNT_W'(1);
      end
      if (cmd.add_write) begin
        if (full) begin
          head <= head_inc;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
    end
  end

  // Captured word and per-word results
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q        <= s_tuser;
      ticks_q     <= s_tdata[15:0];
      freq_q      <= s_tdata[31:16];
      amp_q       <= s_tdata[47:32];
      pan_q       <= s_tdata[63:48];
      track_q     <= s_tdata[66:64];
      offset_q    <= s_tdata[78:67];
      dropped     <= '0;
      overwrote_q <= 1'b0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (cmd.expire_pop) begin
        dropped <= dropped + CNT_W'(1);
      end
      if (cmd.add_write) begin
        overwrote_q <= full;
      end
      if (cmd.read_issue) begin
        rd_valid_q <= offset_in_range;
      end
    end
    if (cmd.mul) begin
      product <= ticks_q * recede_rate;
    end
  end

  assign count32   = 32'(count);
  assign head32    = 32'(head);
  assign dropped32 = 32'(dropped);
  assign entry_out = rd_valid_q ? ram_rdata : '0;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_load) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, entry_out, rd_valid_q,
                  dropped32[aprb_pkg::EXPIRED_W-1:0], overwrote_q,
                  head32[aprb_pkg::SLOT_OUT_W-1:0], count32[aprb_pkg::LIVE_W-1:0]};
    end
  end

  assign status.op         = op_q;
  assign status.expire_hit = (count != '0) && (age >= fade_distance);
  assign status.out_free   = !m_tvalid || m_tready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("live count above capacity");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.expire_pop |-> count != '0)
    else $error("expiry popped an empty ring");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.add_write && !full |=> count == $past(count + CNT_W'(1)))
    else $error("add into a non-full ring did not grow the count");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the aging particle ring buffer
// Streams advance, add and read words into the block under random idling on
// both sides and checks every result word against an in-bench model of the
// ring: directed corners first, then random traffic over several register
// settings, a long output stall and a fill past capacity.
// ----------------------------------------------------------------------------
module tb;

  localparam int CAPACITY    = 4096;
  localparam int SLOT_BITS   = $clog2(CAPACITY);
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE      = 8;

  // Codes the package leaves unnamed
  localparam logic [aprb_pkg::OP_W-1:0]        OP_SPARE     = 2'd3;
  localparam logic [aprb_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [aprb_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [aprb_pkg::OP_W-1:0]          op;
    logic [aprb_pkg::TICKS_W-1:0]       ticks;
    logic [aprb_pkg::FREQ_W-1:0]        freq;
    logic [aprb_pkg::AMP_W-1:0]         amp;
    logic signed [aprb_pkg::PAN_W-1:0]  pan;
    logic [aprb_pkg::TRACK_W-1:0]       track;
    logic [aprb_pkg::OFFSET_W-1:0]      offset;
  } particle_word_t;

  typedef struct packed {
    logic [aprb_pkg::LIVE_W-1:0]        live;
    logic [aprb_pkg::SLOT_OUT_W-1:0]    oldest;
    logic                               overwrote;
    logic [aprb_pkg::EXPIRED_W-1:0]     expired;
    logic                               valid;
    logic [aprb_pkg::FREQ_W-1:0]        freq;
    logic [aprb_pkg::AMP_W-1:0]         amp;
    logic signed [aprb_pkg::PAN_W-1:0]  pan;
    logic [aprb_pkg::TRACK_W-1:0]       track;
    logic [aprb_pkg::DIST_W-1:0]        birth;
  } ring_status_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cfg_we = 1'b0;
  logic [aprb_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [aprb_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
  logic                                 s_tvalid = 1'b0;
  logic                                 s_tready;
  logic [aprb_pkg::IN_TDATA_W-1:0]      s_tdata = '0;
  logic [aprb_pkg::OP_W-1:0]            s_tuser = '0;
  logic                                 m_tvalid;
  logic                                 m_tready = 1'b0;
  logic [aprb_pkg::OUT_TDATA_W-1:0]     m_tdata;

  aging_particle_ring_buffer #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial forever #2 clk = ~clk;

  // Ring model state, kept in step with every accepted word
  logic [aprb_pkg::FREQ_W-1:0]  ring_freq  [CAPACITY];
  logic [aprb_pkg::AMP_W-1:0]   ring_amp   [CAPACITY];
  logic [aprb_pkg::PAN_W-1:0]   ring_pan   [CAPACITY];
  logic [aprb_pkg::TRACK_W-1:0] ring_track [CAPACITY];
  logic [aprb_pkg::DIST_W-1:0]  ring_birth [CAPACITY];
  int unsigned                  model_head = 0;
  int unsigned                  model_live = 0;
  logic [aprb_pkg::DIST_W-1:0]  model_distance = '0;
  logic [aprb_pkg::DIST_W-1:0]  model_fade = aprb_pkg::FADE_DISTANCE_RST;
  logic [aprb_pkg::RATE_W-1:0]  model_rate = aprb_pkg::RECEDE_RATE_RST;

  ring_status_t pending_status[$];

  int          fail_count = 0;
  int          n_add = 0, n_overwrite = 0, n_read = 0, n_hit = 0;
  int          n_advance = 0, n_spare = 0, n_expired = 0, max_expired = 0;
  int unsigned cycle_count = 0;

  // Idling controls shared by sender, receiver and the tests
  bit steady = 1'b0;
  int sink_hold = 0;
  bit sink_holding = 1'b0;

  // Apply one word to the model and return the result it must produce
  function automatic ring_status_t ring_step(particle_word_t w);
    ring_status_t                r;
    logic [aprb_pkg::DIST_W-1:0] age;
    logic [SLOT_BITS-1:0]        slot;
    r    = '0;
    slot = '0;
    case (w.op)
      aprb_pkg::OP_ADVANCE: begin
        n_advance++;
        model_distance = model_distance + 32'(w.ticks) * 32'(model_rate);
        // drop from the oldest end while the age reaches the fade distance
        while (model_live > 0) begin
          age = model_distance - ring_birth[SLOT_BITS'(model_head)];
          if (age < model_fade) break;
          model_head = (model_head + 1) % CAPACITY;
          model_live--;
          r.expired = r.expired + (aprb_pkg::EXPIRED_W)'(1);
        end
        n_expired += int'(r.expired);
        if (int'(r.expired) > max_expired) max_expired = int'(r.expired);
      end
      aprb_pkg::OP_ADD: begin
        n_add++;
        if (model_live >= CAPACITY) begin
          // full: overwrite the oldest and move the head past it
          slot = SLOT_BITS'(model_head);
          model_head = (model_head + 1) % CAPACITY;
          r.overwrote = 1'b1;
          n_overwrite++;
        end else begin
          slot = SLOT_BITS'((model_head + model_live) % CAPACITY);
          model_live++;
        end
        ring_freq[slot]  = w.freq;
        ring_amp[slot]   = w.amp;
        ring_pan[slot]   = w.pan;
        ring_track[slot] = w.track;
        ring_birth[slot] = model_distance;
      end
      aprb_pkg::OP_READ: begin
        n_read++;
        if (32'(w.offset) < model_live) begin
          slot    = SLOT_BITS'((model_head + 32'(w.offset)) % CAPACITY);
          r.valid = 1'b1;
          r.freq  = ring_freq[slot];
          r.amp   = ring_amp[slot];
          r.pan   = ring_pan[slot];
          r.track = ring_track[slot];
          r.birth = ring_birth[slot];
          n_hit++;
        end
      end
      default: n_spare++;
    endcase
    r.live   = (aprb_pkg::LIVE_W)'(model_live);
    r.oldest = (aprb_pkg::SLOT_OUT_W)'(model_head);
    return r;
  endfunction

  function automatic logic [aprb_pkg::IN_TDATA_W-1:0] pack_word(particle_word_t w);
    return {1'b0, w.offset, w.track, w.pan, w.amp, w.freq, w.ticks};
  endfunction

  function automatic ring_status_t unpack_status(logic [aprb_pkg::OUT_TDATA_W-1:0] d);
    ring_status_t r;
    r.live      = d[12:0];
    r.oldest    = d[24:13];
    r.overwrote = d[25];
    r.expired   = d[38:26];
    r.valid     = d[39];
    r.freq      = d[55:40];
    r.amp       = d[71:56];
    r.pan       = d[87:72];
    r.track     = d[90:88];
    r.birth     = d[122:91];
    return r;
  endfunction

  function automatic particle_word_t compose(logic [aprb_pkg::OP_W-1:0] op,
                                            int unsigned ticks, int unsigned freq,
                                            int unsigned amp, int pan,
                                            int unsigned track, int unsigned offset);
    particle_word_t w;
    w.op     = op;
    w.ticks  = (aprb_pkg::TICKS_W)'(ticks);
    w.freq   = (aprb_pkg::FREQ_W)'(freq);
    w.amp    = (aprb_pkg::AMP_W)'(amp);
    w.pan    = (aprb_pkg::PAN_W)'(pan);
    w.track  = (aprb_pkg::TRACK_W)'(track);
    w.offset = (aprb_pkg::OFFSET_W)'(offset);
    return w;
  endfunction

  // Every field random; callers then set what the operation uses
  function automatic particle_word_t noisy_word(logic [aprb_pkg::OP_W-1:0] op);
    logic [127:0]   raw;
    particle_word_t w;
    raw  = {$urandom, $urandom, $urandom, $urandom};
    w    = raw[$bits(particle_word_t)-1:0];
    w.op = op;
    return w;
  endfunction

  function automatic logic [aprb_pkg::TICKS_W-1:0] pick_ticks();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return (aprb_pkg::TICKS_W)'($urandom_range(0, 300));
    if (r < 95) return (aprb_pkg::TICKS_W)'($urandom_range(0, 65535));
    return '0;
  endfunction

  // Mostly live offsets, the rest anywhere in range
  function automatic logic [aprb_pkg::OFFSET_W-1:0] pick_offset();
    if (model_live > 0 && $urandom_range(0, 9) < 7)
      return (aprb_pkg::OFFSET_W)'($urandom_range(0, model_live - 1));
    return (aprb_pkg::OFFSET_W)'($urandom_range(0, CAPACITY - 1));
  endfunction

  function automatic int idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int field_diff(string name, logic [63:0] want, logic [63:0] got);
    if (want === got) return 0;
    $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
    return 1;
  endfunction

  // Offer one word, hold it until taken, then log what it must produce
  task automatic send_word(particle_word_t w);
    int gap;
    gap = steady ? 0 : idle_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_word(w);
    s_tuser  <= w.op;
    do @(posedge clk); while (!s_tready);
    pending_status.push_back(ring_step(w));
  endtask

  // Stop offering and hold until every result has come back
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [aprb_pkg::CFG_INDEX_W-1:0] idx,
                           logic [aprb_pkg::CFG_DATA_W-1:0] val);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      aprb_pkg::REG_FADE_DISTANCE: model_fade = val;
      aprb_pkg::REG_RECEDE_RATE:   model_rate = val[aprb_pkg::RATE_W-1:0];
      default: ;
    endcase
  endtask

  // Empty store, field extremes, out-of-range reads, spare operation code
  task automatic test_directed_edges();
    send_word(compose(aprb_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 0));
    send_word(compose(aprb_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
    send_word(compose(aprb_pkg::OP_READ, 0, 0, 0, 0, 0, CAPACITY - 1));
    send_word(compose(OP_SPARE, 65535, 65535, 65535, -1, 7, CAPACITY - 1));
    send_word(compose(aprb_pkg::OP_ADD, 0, 65535, 65535, -32768, 7, 0));
    send_word(compose(aprb_pkg::OP_ADD, 0, 0, 0, 0, 0, 0));
    send_word(compose(aprb_pkg::OP_ADD, 0, 1, 32768, 32767, 5, 0));
    send_word(compose(aprb_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
    send_word(compose(aprb_pkg::OP_READ, 0, 0, 0, 0, 0, 2));
    send_word(compose(aprb_pkg::OP_READ, 0, 0, 0, 0, 0, 3));
    send_word(compose(aprb_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 0));
    send_word(compose(OP_SPARE, 0, 0, 0, 0, 0, 0));
    send_word(compose(aprb_pkg::OP_ADVANCE, 65535, 0, 0, 0, 0, 0));
    send_word(compose(aprb_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
  endtask

  // Age exactly at the fade distance, then a fade distance of zero
  task automatic test_fade_edges();
    write_reg(aprb_pkg::REG_RECEDE_RATE, 32'(aprb_pkg::RECEDE_RATE_RST));
    write_reg(aprb_pkg::REG_FADE_DISTANCE, 32'd6550);
    send_word(noisy_word(aprb_pkg::OP_ADD));
    send_word(compose(aprb_pkg::OP_ADVANCE, 9, 0, 0, 0, 0, 0));
    send_word(compose(aprb_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
    send_word(compose(aprb_pkg::OP_ADVANCE, 1, 0, 0, 0, 0, 0));
    write_reg(aprb_pkg::REG_FADE_DISTANCE, 32'd0);
    send_word(noisy_word(aprb_pkg::OP_ADD));
    send_word(noisy_word(aprb_pkg::OP_ADD));
    send_word(compose(aprb_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 0));
  endtask

  // Largest steps so the distance accumulator wraps past 2^32
  task automatic test_distance_wrap();
    write_reg(aprb_pkg::REG_RECEDE_RATE, 32'hFFFF_FFFF);
    write_reg(aprb_pkg::REG_FADE_DISTANCE, 32'hFFFF_FFFF);
    send_word(noisy_word(aprb_pkg::OP_ADD));
    send_word(compose(aprb_pkg::OP_ADVANCE, 65535, 0, 0, 0, 0, 0));
    send_word(noisy_word(aprb_pkg::OP_ADD));
    send_word(compose(aprb_pkg::OP_ADVANCE, 65535, 0, 0, 0, 0, 0));
    send_word(compose(aprb_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
    send_word(compose(aprb_pkg::OP_READ, 0, 0, 0, 0, 0, 1));
    write_reg(aprb_pkg::REG_FADE_DISTANCE, 32'h8000_0000);
    send_word(compose(aprb_pkg::OP_ADVANCE, 65535, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic();
    particle_word_t w;
    int unsigned    pick;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(aprb_pkg::REG_FADE_DISTANCE, aprb_pkg::FADE_DISTANCE_RST);
          write_reg(aprb_pkg::REG_RECEDE_RATE,
                    {16'($urandom), aprb_pkg::RECEDE_RATE_RST});
        end
        1: begin
          write_reg(aprb_pkg::REG_FADE_DISTANCE, 32'hFFFF_FFFF);
          write_reg(aprb_pkg::REG_RECEDE_RATE, {16'($urandom), 16'hFFFF});
        end
        2: begin
          write_reg(aprb_pkg::REG_FADE_DISTANCE, 32'd0);
          write_reg(aprb_pkg::REG_RECEDE_RATE, 32'd0);
        end
        3: begin
          write_reg(aprb_pkg::REG_FADE_DISTANCE, $urandom);
          write_reg(aprb_pkg::REG_RECEDE_RATE, $urandom);
        end
        default: begin
          write_reg(aprb_pkg::REG_FADE_DISTANCE,
                    $urandom_range(32'h1_0000, 32'h40_0000));
          write_reg(aprb_pkg::REG_RECEDE_RATE, $urandom_range(1, 4000));
        end
      endcase
      // indexes past the last register must leave the settings alone
      write_reg(phase % 2 ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
      for (int i = 0; i < 220; i++) begin
        if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          w = noisy_word(aprb_pkg::OP_ADD);
        end else if (pick < 70) begin
          w = noisy_word(aprb_pkg::OP_READ);
          w.offset = pick_offset();
        end else if (pick < 95) begin
          w = noisy_word(aprb_pkg::OP_ADVANCE);
          w.ticks = pick_ticks();
        end else begin
          w = noisy_word(OP_SPARE);
        end
        send_word(w);
        if ($urandom_range(0, 149) == 0) wait_quiet();
      end
      steady = 1'b0;
    end
  endtask

  // Hold the output off for a long stretch while words keep coming
  task automatic test_output_stall();
    particle_word_t w;
    wait_quiet();
    steady    = 1'b1;
    sink_hold = 300;
    while (!sink_holding) @(posedge clk);
    for (int i = 0; i < 40; i++) begin
      w = noisy_word(i % 3 == 2 ? aprb_pkg::OP_READ : aprb_pkg::OP_ADD);
      if (w.op == aprb_pkg::OP_READ) w.offset = pick_offset();
      send_word(w);
    end
    steady = 1'b0;
  endtask

  // Fill the store, overwrite past capacity, read deep offsets, then drop all
  task automatic test_fill_and_overwrite();
    particle_word_t w;
    int unsigned    adds_left;
    int unsigned    pick;
    write_reg(aprb_pkg::REG_FADE_DISTANCE, 32'hFFFF_FFFF);
    write_reg(aprb_pkg::REG_RECEDE_RATE, 32'd3);
    adds_left = CAPACITY - model_live + 48;
    while (adds_left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        w = noisy_word(aprb_pkg::OP_ADD);
        adds_left--;
      end else if (pick < 95) begin
        w = noisy_word(aprb_pkg::OP_READ);
        w.offset = pick_offset();
      end else begin
        w = noisy_word(aprb_pkg::OP_ADVANCE);
        w.ticks = (aprb_pkg::TICKS_W)'($urandom_range(0, 255));
      end
      send_word(w);
    end
    for (int i = 0; i < 40; i++) begin
      w = noisy_word(aprb_pkg::OP_READ);
      w.offset = (aprb_pkg::OFFSET_W)'($urandom_range(CAPACITY / 2, CAPACITY - 1));
      send_word(w);
    end
    write_reg(aprb_pkg::REG_FADE_DISTANCE, 32'd0);
    send_word(noisy_word(aprb_pkg::OP_ADVANCE));
    send_word(compose(aprb_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
    send_word(noisy_word(aprb_pkg::OP_ADD));
    send_word(compose(aprb_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
  endtask

  // Result sink: random stalls, long holds on request
  initial begin : result_sink
    int n;
    @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        n            = sink_hold;
        sink_hold    = 0;
        sink_holding = 1'b1;
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
        sink_holding = 1'b0;
      end else begin
        n = steady ? 0 : idle_gap();
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin : result_check
    ring_status_t want;
    ring_status_t got;
    int           bad;
    if (!rst && m_tvalid && m_tready) begin
      got = unpack_status(m_tdata);
      if (pending_status.size() == 0) begin
        $display("%0t ns: result word %h with nothing expected", $time, m_tdata);
        fail_count++;
      end else begin
        want = pending_status.pop_front();
        bad  = 0;
        bad += field_diff("live_count", 64'(want.live), 64'(got.live));
        bad += field_diff("oldest_slot", 64'(want.oldest), 64'(got.oldest));
        bad += field_diff("overwrote", 64'(want.overwrote), 64'(got.overwrote));
        bad += field_diff("expired_count", 64'(want.expired), 64'(got.expired));
        bad += field_diff("entry_valid", 64'(want.valid), 64'(got.valid));
        bad += field_diff("entry_frequency", 64'(want.freq), 64'(got.freq));
        bad += field_diff("entry_amplitude", 64'(want.amp), 64'(got.amp));
        bad += field_diff("entry_pan", 64'($unsigned(want.pan)),
                          64'($unsigned(got.pan)));
        bad += field_diff("entry_track", 64'(want.track), 64'(got.track));
        bad += field_diff("entry_birth", 64'(want.birth), 64'(got.birth));
        bad += field_diff("tdata padding", 64'(0),
                          64'(m_tdata[aprb_pkg::OUT_TDATA_W-1:123]));
        if (bad != 0) fail_count++;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t ns: run stopped at the cycle limit (%0d cycles)", $time, cycle_count);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_fade_edges();
    test_distance_wrap();
    test_random_traffic();
    test_output_stall();
    test_fill_and_overwrite();
    wait_quiet();
    repeat (16) @(posedge clk);
    $display("Covered %0d adds (%0d over a full ring), %0d reads (%0d of live entries),",
             n_add, n_overwrite, n_read, n_hit);
    $display("%0d advances expiring %0d entries (up to %0d at once); %0d spare-code words",
             n_advance, n_expired, max_expired, n_spare);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
